### design/mseu_pkg.sv
// mseu_pkg: shared constants, opcodes and request/result types for the
// execute unit. Used by all files in the design folder; no dependencies.

package mseu_pkg;

	localparam int DATA_WORDS = 2048;
	localparam int REG_COUNT  = 32;
	localparam int DM_AW      = $clog2(DATA_WORDS);
	localparam int RF_AW      = $clog2(REG_COUNT);

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_ADDI = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_BEQ  = 3'd4;
	localparam logic [2:0] OP_LW   = 3'd5;
	localparam logic [2:0] OP_SW   = 3'd6;
	localparam logic [2:0] OP_NOP  = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  dest_reg;
		logic [4:0]  src_reg_a;
		logic [4:0]  src_reg_b;
		logic [15:0] immediate;
	} instr_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  written_reg;
		logic [31:0] written_value;
		logic        branch_taken;
		logic        mem_fault;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [RF_AW-1:0] addr;
		logic [31:0]      data;
	} rf_wr_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [DM_AW-1:0] addr;
		logic [31:0]      wdata;
	} dm_req_t;

endpackage

### design/mseu_regfile.sv
// mseu_regfile: 32-entry register file, two registered read ports, one
// write port, per-entry valid bits so unwritten entries read as zero.
// Depends on mseu_pkg.

module mseu_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [mseu_pkg::RF_AW-1:0] rd_addr_a,
	input  logic [mseu_pkg::RF_AW-1:0] rd_addr_b,
	input  mseu_pkg::rf_wr_t           wr,
	output logic [31:0]                rd_data_a,
	output logic [31:0]                rd_data_b
);
	import mseu_pkg::*;

	logic [31:0]          rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [31:0]          data_a_q;
	logic [31:0]          data_b_q;
	logic                 vld_a_q;
	logic                 vld_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			rf_mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			data_a_q <= rf_mem[rd_addr_a];
			data_b_q <= rf_mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[rd_addr_a];
				vld_b_q <= vld_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = vld_a_q ? data_a_q : '0;
	assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule

### design/mseu_dmem.sv
// mseu_dmem: word-indexed data memory with a registered read port and a
// zero-fill sweep after reset. Depends on mseu_pkg.

module mseu_dmem (
	input  logic              clk,
	input  logic              arst_n,
	input  mseu_pkg::dm_req_t req,
	output logic [31:0]       rd_data,
	output logic              busy
);
	import mseu_pkg::*;

	logic [31:0]      dm_mem [DATA_WORDS];
	logic [31:0]      rdata_q;
	logic             clr_q;
	logic [DM_AW-1:0] clr_addr_q;

	always_ff @(posedge clk) begin
		if (clr_q) begin
			dm_mem[clr_addr_q] <= '0;
		end else if (req.wr_en) begin
			dm_mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= dm_mem[req.addr];
		end
	end

	// one word per cycle until the last entry is zeroed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == DM_AW'(DATA_WORDS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign rd_data = rdata_q;
	assign busy    = clr_q;

endmodule

### design/mips_subset_execute_unit.sv
// mips_subset_execute_unit: two-stage execute pipeline over a register
// file and a data memory. Depends on mseu_pkg, mseu_regfile, mseu_dmem.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-------------------------
//   instr    | instr_valid   | instr_stall   | instr  (mseu_pkg::instr_t)
//   result   | result_valid  | result_stall  | result (mseu_pkg::result_t)
//
// one instruction per cycle sustained while result_stall is low; a result
// appears once its request has passed the register file read, then execute
// and memory access. after reset the data memory is zeroed, instr_stall high.
// register results are forwarded from the output stage and the last write,
// so dependent instructions issue back to back.
// a stalled result holds the output stage; a new request still enters
// the execute stage while that stage is empty.

module mips_subset_execute_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              instr_valid,
	output logic              instr_stall,
	input  mseu_pkg::instr_t  instr,
	output logic              result_valid,
	input  logic              result_stall,
	output mseu_pkg::result_t result
);
	import mseu_pkg::*;

	// stage 1: operands arriving from the register file
	logic        v_s1;
	instr_t      ins_s1;

	// stage 2: output stage
	logic        v_s2;
	logic [31:0] pc_s2;
	logic        wr_s2;
	logic [4:0]  wreg_s2;
	logic [31:0] res_s2;
	logic        lw_s2;
	logic        taken_s2;
	logic        fault_s2;

	logic [31:0] pc_q;
	rf_wr_t      byp_q;

	logic        accept;
	logic        out_fire;
	logic        s2_free;
	logic        s1_adv;
	logic        dm_busy;

	logic [31:0] rf_rdata_a;
	logic [31:0] rf_rdata_b;
	logic [31:0] dm_rdata;
	rf_wr_t      rf_wr;
	dm_req_t     dm_req;

	logic [31:0] s2_wval;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] imm32;
	logic [31:0] sum_ai;
	logic [31:0] pc_plus4;
	logic [31:0] pc_c;
	logic [31:0] res_c;
	logic [4:0]  wreg_c;
	logic        wr_c;
	logic        taken_c;
	logic        fault_c;
	logic        is_mem_c;

	// newest producer wins: output stage, then the write done at read time
	function automatic logic [31:0] fwd_operand(
		input logic [4:0]  addr,
		input logic [31:0] rf_val,
		input logic        s2_hit_en,
		input logic [4:0]  s2_addr,
		input logic [31:0] s2_val,
		input rf_wr_t      byp
	);
		logic [31:0] val;
		priority if (s2_hit_en && s2_addr == addr) begin
			val = s2_val;
		end else if (byp.en && byp.addr == addr) begin
			val = byp.data;
		end else begin
			val = rf_val;
		end
		return val;
	endfunction

	assign out_fire    = v_s2 && !result_stall;
	assign s2_free     = !v_s2 || !result_stall;
	assign s1_adv      = v_s1 && s2_free;
	assign instr_stall = dm_busy || (v_s1 && !s2_free);
	assign accept      = instr_valid && !instr_stall;

	assign s2_wval = lw_s2 ? dm_rdata : res_s2;

	assign rf_wr.en   = out_fire && wr_s2;
	assign rf_wr.addr = wreg_s2;
	assign rf_wr.data = s2_wval;

	mseu_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (instr.src_reg_a),
		.rd_addr_b (instr.src_reg_b),
		.wr        (rf_wr),
		.rd_data_a (rf_rdata_a),
		.rd_data_b (rf_rdata_b)
	);

	always_comb begin
		op_a = fwd_operand(ins_s1.src_reg_a, rf_rdata_a, v_s2 && wr_s2, wreg_s2,
			s2_wval, byp_q);
		op_b = fwd_operand(ins_s1.src_reg_b, rf_rdata_b, v_s2 && wr_s2, wreg_s2,
			s2_wval, byp_q);
	end

	always_comb begin
		imm32    = 32'(ins_s1.immediate);
		sum_ai   = op_a + imm32;
		is_mem_c = (ins_s1.action == OP_LW) || (ins_s1.action == OP_SW);
		fault_c  = is_mem_c && (sum_ai >= 32'(DATA_WORDS));
		wr_c     = 1'b0;
		wreg_c   = ins_s1.dest_reg;
		res_c    = '0;
		taken_c  = 1'b0;
		unique case (ins_s1.action)
			OP_ADD: begin
				wr_c  = 1'b1;
				res_c = op_a + op_b;
			end
			OP_ADDI: begin
				wr_c   = 1'b1;
				wreg_c = ins_s1.src_reg_b;
				res_c  = sum_ai;
			end
			OP_SUB: begin
				wr_c  = 1'b1;
				res_c = op_a - op_b;
			end
			OP_MUL: begin
				wr_c  = 1'b1;
				res_c = op_a * op_b;
			end
			OP_BEQ: begin
				taken_c = (op_a == op_b);
			end
			OP_LW: begin
				wr_c   = !fault_c;
				wreg_c = ins_s1.src_reg_b;
			end
			OP_SW: begin
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
		// register zero stays zero
		if (wreg_c == '0) begin
			wr_c = 1'b0;
		end
		if (!wr_c) begin
			wreg_c = '0;
			res_c  = '0;
		end
		pc_plus4 = pc_q + 32'd4;
		pc_c     = taken_c ? pc_plus4 + {imm32[29:0], 2'b00} : pc_plus4;
	end

	assign dm_req.rd_en = s1_adv && (ins_s1.action == OP_LW) && !fault_c;
	assign dm_req.wr_en = s1_adv && (ins_s1.action == OP_SW) && !fault_c;
	assign dm_req.addr  = sum_ai[DM_AW-1:0];
	assign dm_req.wdata = op_b;

	mseu_dmem u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dm_req),
		.rd_data (dm_rdata),
		.busy    (dm_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			pc_q  <= '0;
			byp_q <= '0;
		end else begin
			if (accept) begin
				v_s1  <= 1'b1;
				byp_q <= rf_wr;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				v_s2 <= 1'b1;
				pc_q <= pc_c;
			end else if (out_fire) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1 <= instr;
		end
		if (s1_adv) begin
			pc_s2    <= pc_c;
			wr_s2    <= wr_c;
			wreg_s2  <= wreg_c;
			res_s2   <= res_c;
			lw_s2    <= (ins_s1.action == OP_LW) && !fault_c;
			taken_s2 <= taken_c;
			fault_s2 <= fault_c;
		end
	end

	assign result_valid         = v_s2;
	assign result.next_pc       = pc_s2;
	assign result.reg_written   = wr_s2;
	assign result.written_reg   = wreg_s2;
	assign result.written_value = wr_s2 ? s2_wval : '0;
	assign result.branch_taken  = taken_s2;
	assign result.mem_fault     = fault_s2;

`ifndef ASSERT_OFF
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.en |-> rf_wr.addr != '0)
		else $error("register zero written");

	a_empty_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		dm_busy |-> (!v_s1 && !v_s2))
		else $error("pipeline busy during memory clear");

	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !taken_c) |=> pc_q == $past(pc_q) + 32'd4)
		else $error("pc did not advance by one word");
`endif

endmodule
